// ----- hw/rtl/drsc_pkg.sv -----
// Shared constants, types and classification functions for the sensor classifier.
`timescale 1ns / 1ps

package drsc_pkg;

	// Window geometry
	localparam int WINDOW_DEPTH = 10;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int SAMPLE_W     = 12;
	localparam int SUM_W        = 16;
	localparam int CLASS_W      = 2;

	// Divide by WINDOW_DEPTH as multiply by a rounded-up reciprocal and shift;
	// exact for every SUM_W-bit dividend.
	localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_DEPTH);
	localparam int RECIP_W   = SUM_W + 1;
	localparam int PROD_W    = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIFF  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 2'd2;

	// Reset values of the registers
	localparam logic [SAMPLE_W-1:0] LINE_RST   = 12'd800;
	localparam logic [SAMPLE_W-1:0] CLIFF_RST  = 12'd2000;
	localparam logic [SAMPLE_W-1:0] MARGIN_RST = 12'd50;

	// Surface classes
	localparam logic [CLASS_W-1:0] CLASS_LINE  = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_FLOOR = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_CLIFF = 2'd2;

	// Payload widths
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic [SAMPLE_W-1:0] line_thr;
		logic [SAMPLE_W-1:0] cliff_thr;
		logic [SAMPLE_W-1:0] margin;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic [CLASS_W-1:0]  cls;
		logic                unstable;
	} chan_res_t;

	typedef struct packed {
		chan_res_t right;
		chan_res_t left;
	} result_t;

	// Line test first, then cliff, else floor
	function automatic logic [CLASS_W-1:0] surface_kind(
		input logic [SAMPLE_W-1:0] m,
		input cfg_t                cfg
	);
		logic [CLASS_W-1:0] k;
		if (m < cfg.line_thr) begin
			k = CLASS_LINE;
		end else if (m > cfg.cliff_thr) begin
			k = CLASS_CLIFF;
		end else begin
			k = CLASS_FLOOR;
		end
		return k;
	endfunction

	// t - g < m < t + g, rewritten without a negative term so it never wraps
	function automatic logic near_edge(
		input logic [SAMPLE_W-1:0] m,
		input logic [SAMPLE_W-1:0] t,
		input logic [SAMPLE_W-1:0] g
	);
		logic [SAMPLE_W:0] m_plus;
		logic [SAMPLE_W:0] t_plus;
		m_plus = {1'b0, m} + {1'b0, g};
		t_plus = {1'b0, t} + {1'b0, g};
		return (m_plus > {1'b0, t}) && ({1'b0, m} < t_plus);
	endfunction

endpackage

// ----- hw/rtl/drsc_lane.sv -----
// One channel lane: sample window, running sum and registered window mean.
`timescale 1ns / 1ps

module drsc_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           prime,
	input  logic [drsc_pkg::SAMPLE_W-1:0]  sample,
	input  logic [drsc_pkg::SLOT_W-1:0]    slot,
	input  logic                           adv,
	output logic [drsc_pkg::SAMPLE_W-1:0]  mean_s2
);

	logic [drsc_pkg::SAMPLE_W-1:0] win_q [drsc_pkg::WINDOW_DEPTH];
	logic [drsc_pkg::SUM_W-1:0]    sum_q;
	logic [drsc_pkg::SUM_W-1:0]    sum_upd;
	logic [drsc_pkg::SUM_W-1:0]    sum_prime;
	logic [drsc_pkg::PROD_W-1:0]   prod;

	// Replace the oldest sample in the sum, or fill with one sample
	assign sum_upd   = sum_q - drsc_pkg::SUM_W'(win_q[slot])
	                   + drsc_pkg::SUM_W'(sample);
	assign sum_prime = drsc_pkg::SUM_W'(drsc_pkg::SUM_W'(sample)
	                   * drsc_pkg::SUM_W'(drsc_pkg::WINDOW_DEPTH));

	// Window and running sum; the sum register is the first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < drsc_pkg::WINDOW_DEPTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (load) begin
			if (prime) begin
				sum_q <= sum_prime;
				for (int i = 0; i < drsc_pkg::WINDOW_DEPTH; i++) begin
					win_q[i] <= sample;
				end
			end else begin
				sum_q       <= sum_upd;
				win_q[slot] <= sample;
			end
		end
	end

	// Mean by reciprocal multiply
	assign prod = drsc_pkg::PROD_W'(sum_q) * drsc_pkg::PROD_W'(drsc_pkg::DIV_RECIP);

	always_ff @(posedge clk) begin
		if (adv) begin
			mean_s2 <= prod[drsc_pkg::DIV_SHIFT +: drsc_pkg::SAMPLE_W];
		end
	end

endmodule

// ----- hw/rtl/drsc_merge.sv -----
// Merge stage: classifies both lane means and forms one result item.
`timescale 1ns / 1ps

module drsc_merge (
	input  logic [drsc_pkg::SAMPLE_W-1:0] left_mean,
	input  logic [drsc_pkg::SAMPLE_W-1:0] right_mean,
	input  drsc_pkg::cfg_t                cfg,
	output drsc_pkg::result_t             res
);

	// Left channel, then right channel
	always_comb begin
		res.left.mean     = left_mean;
		res.left.cls      = drsc_pkg::surface_kind(left_mean, cfg);
		res.left.unstable =
			drsc_pkg::near_edge(left_mean, cfg.line_thr, cfg.margin) ||
			drsc_pkg::near_edge(left_mean, cfg.cliff_thr, cfg.margin);

		res.right.mean     = right_mean;
		res.right.cls      = drsc_pkg::surface_kind(right_mean, cfg);
		res.right.unstable =
			drsc_pkg::near_edge(right_mean, cfg.line_thr, cfg.margin) ||
			drsc_pkg::near_edge(right_mean, cfg.cliff_thr, cfg.margin);
	end

endmodule

// ----- hw/rtl/dual_reflective_sensor_classifier_top.sv -----
// An accepted item passes the lane sum, lane mean and output registers to m_tvalid.
// Throughput: 1 item per cycle, set by the lane window/sum update, while skid is empty.
// The output register plus a one-item skid buffer decouple s_tready from m_tready.
// Reset (arst_n low, asynchronous): windows, running sums and write slot cleared,
// thresholds back to 800 / 2000 / margin 50, no items in flight.
`timescale 1ns / 1ps

module dual_reflective_sensor_classifier_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port
	input  logic                              cfg_we,
	input  logic [drsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [drsc_pkg::SAMPLE_W-1:0]     cfg_data,
	// Input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [drsc_pkg::IN_DATA_W-1:0]    s_tdata,  // left_sample, right_sample
	input  logic                              s_tuser,  // command (1 = prime)
	// Output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// left_mean, left_class, left_unstable, right_mean, right_class, right_unstable, pad
	output logic [drsc_pkg::OUT_DATA_W-1:0]   m_tdata
);

	localparam int RES_W = $bits(drsc_pkg::result_t);

	drsc_pkg::cfg_t                 cfg_q;
	logic [drsc_pkg::SLOT_W-1:0]    slot_q;
	logic                           valid_s1_q;
	logic                           valid_s2_q;
	logic                           adv;
	logic                           accept;
	logic [drsc_pkg::SAMPLE_W-1:0]  left_mean_s2;
	logic [drsc_pkg::SAMPLE_W-1:0]  right_mean_s2;
	drsc_pkg::result_t              res;
	drsc_pkg::result_t              out_q;
	drsc_pkg::result_t              skid_q;
	logic                           out_valid_q;
	logic                           skid_valid_q;

	// Pipeline moves whenever the skid buffer is empty
	assign adv      = !skid_valid_q;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_thr  <= drsc_pkg::LINE_RST;
			cfg_q.cliff_thr <= drsc_pkg::CLIFF_RST;
			cfg_q.margin    <= drsc_pkg::MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				drsc_pkg::REG_LINE:   cfg_q.line_thr  <= cfg_data;
				drsc_pkg::REG_CLIFF:  cfg_q.cliff_thr <= cfg_data;
				drsc_pkg::REG_MARGIN: cfg_q.margin    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared write slot, advanced by update items only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (accept && !s_tuser) begin
			if (slot_q == drsc_pkg::SLOT_W'(drsc_pkg::WINDOW_DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else if (adv) begin
			valid_s1_q <= accept;
			valid_s2_q <= valid_s1_q;
		end
	end

	// Channel lanes
	drsc_lane u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.prime   (s_tuser),
		.sample  (s_tdata[11:0]),
		.slot    (slot_q),
		.adv     (adv),
		.mean_s2 (left_mean_s2)
	);

	drsc_lane u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.prime   (s_tuser),
		.sample  (s_tdata[23:12]),
		.slot    (slot_q),
		.adv     (adv),
		.mean_s2 (right_mean_s2)
	);

	// Classification and merge
	drsc_merge u_merge (
		.left_mean  (left_mean_s2),
		.right_mean (right_mean_s2),
		.cfg        (cfg_q),
		.res        (res)
	);

	// Output register with one-item skid buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (valid_s2_q) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload of the output side
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (valid_s2_q) begin
			if (out_valid_q && !m_tready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(drsc_pkg::OUT_DATA_W - RES_W){1'b0}},
	                   out_q.right.unstable, out_q.right.cls, out_q.right.mean,
	                   out_q.left.unstable, out_q.left.cls, out_q.left.mean};

endmodule

// ----- verif/dual_reflective_sensor_classifier_top_tb.sv -----
// Self-checking testbench for the dual reflective sensor window classifier.
`timescale 1ns / 1ps

module dual_reflective_sensor_classifier_top_tb;

	// Predicts the per-channel window means and classes and checks results in order
	class window_scoreboard;
		logic [drsc_pkg::SAMPLE_W-1:0] line_thr;
		logic [drsc_pkg::SAMPLE_W-1:0] cliff_thr;
		logic [drsc_pkg::SAMPLE_W-1:0] margin;
		logic [drsc_pkg::SAMPLE_W-1:0] left_win[drsc_pkg::WINDOW_DEPTH];
		logic [drsc_pkg::SAMPLE_W-1:0] right_win[drsc_pkg::WINDOW_DEPTH];
		int unsigned                   slot;
		logic [drsc_pkg::SUM_W-1:0]    left_sum;
		logic [drsc_pkg::SUM_W-1:0]    right_sum;
		drsc_pkg::result_t             pending_results[$];
		int unsigned                   errors;
		int unsigned                   checked;

		function new();
			line_thr  = drsc_pkg::LINE_RST;
			cliff_thr = drsc_pkg::CLIFF_RST;
			margin    = drsc_pkg::MARGIN_RST;
			foreach (left_win[k]) begin
				left_win[k]  = '0;
				right_win[k] = '0;
			end
			slot      = 0;
			left_sum  = '0;
			right_sum = '0;
			errors    = 0;
			checked   = 0;
		endfunction

		function void set_reg(logic [drsc_pkg::CFG_IDX_W-1:0] idx,
			logic [drsc_pkg::SAMPLE_W-1:0] val);
			case (idx)
				drsc_pkg::REG_LINE: begin
					line_thr = val;
				end
				drsc_pkg::REG_CLIFF: begin
					cliff_thr = val;
				end
				drsc_pkg::REG_MARGIN: begin
					margin = val;
				end
				default: begin
				end
			endcase
		endfunction

		// Open band around an edge, in signed full precision
		function bit near_band(int m, int edge_val);
			return (m > edge_val - int'(margin)) && (m < edge_val + int'(margin));
		endfunction

		function drsc_pkg::chan_res_t grade(logic [drsc_pkg::SUM_W-1:0] sum);
			drsc_pkg::chan_res_t c;
			int                  m;
			m = int'(sum) / drsc_pkg::WINDOW_DEPTH;
			c.mean = m[drsc_pkg::SAMPLE_W-1:0];
			// line test wins when thresholds overlap
			if (c.mean < line_thr) begin
				c.cls = drsc_pkg::CLASS_LINE;
			end else if (c.mean > cliff_thr) begin
				c.cls = drsc_pkg::CLASS_CLIFF;
			end else begin
				c.cls = drsc_pkg::CLASS_FLOOR;
			end
			c.unstable = near_band(int'(c.mean), int'(line_thr)) ||
				near_band(int'(c.mean), int'(cliff_thr));
			return c;
		endfunction

		function void note_input(logic prime, logic [drsc_pkg::SAMPLE_W-1:0] l,
			logic [drsc_pkg::SAMPLE_W-1:0] r);
			drsc_pkg::result_t res;
			if (prime) begin
				// fill both windows, write slot stays put
				foreach (left_win[k]) begin
					left_win[k]  = l;
					right_win[k] = r;
				end
				left_sum  = drsc_pkg::SUM_W'(int'(l) * drsc_pkg::WINDOW_DEPTH);
				right_sum = drsc_pkg::SUM_W'(int'(r) * drsc_pkg::WINDOW_DEPTH);
			end else begin
				left_sum  = left_sum - drsc_pkg::SUM_W'(left_win[slot])
					+ drsc_pkg::SUM_W'(l);
				right_sum = right_sum - drsc_pkg::SUM_W'(right_win[slot])
					+ drsc_pkg::SUM_W'(r);
				left_win[slot]  = l;
				right_win[slot] = r;
				slot = (slot + 1 == drsc_pkg::WINDOW_DEPTH) ? 0 : slot + 1;
			end
			res.left  = grade(left_sum);
			res.right = grade(right_sum);
			pending_results.push_back(res);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] MISMATCH: %s", $time, msg);
		endtask

		task check_field(string name, int got, int want);
			if (got != want) begin
				report($sformatf("result %0d %s got %0d expected %0d", checked, name, got, want));
			end
		endtask

		task check_result(logic [drsc_pkg::OUT_DATA_W-1:0] data);
			drsc_pkg::result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result 0x%08h", data));
				return;
			end
			want = pending_results.pop_front();
			check_field("left_mean", int'(data[11:0]), int'(want.left.mean));
			check_field("left_class", int'(data[13:12]), int'(want.left.cls));
			check_field("left_unstable", int'(data[14]), int'(want.left.unstable));
			check_field("right_mean", int'(data[26:15]), int'(want.right.mean));
			check_field("right_class", int'(data[28:27]), int'(want.right.cls));
			check_field("right_unstable", int'(data[29]), int'(want.right.unstable));
			checked++;
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [drsc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [drsc_pkg::SAMPLE_W-1:0]   cfg_data;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [drsc_pkg::IN_DATA_W-1:0]  s_tdata;   // left_sample, right_sample
	logic                            s_tuser;   // command (1 = prime)
	logic                            m_tvalid;
	logic                            m_tready;
	// left mean/class/unstable, right mean/class/unstable
	logic [drsc_pkg::OUT_DATA_W-1:0] m_tdata;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_PRIME  = 1'b1;

	window_scoreboard sb;
	int               tx_calm;
	int               rx_calm;
	int               hold_req;
	int unsigned      n_items;
	int unsigned      n_prime;
	int unsigned      n_settings;

	dual_reflective_sensor_classifier_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Mostly back-to-back, some short gaps, a few long ones, plus calm stretches
	function automatic int gap_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 120);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(15, 40);
	endfunction

	// Sample biased toward the rails and the threshold bands
	function automatic logic [drsc_pkg::SAMPLE_W-1:0] pick_sample();
		int r;
		int t;
		int g;
		int v;
		r = $urandom_range(0, 99);
		if (r < 8) return '0;
		if (r < 16) return '1;
		if (r < 45) begin
			t = ($urandom_range(0, 1) == 0) ? int'(sb.line_thr) : int'(sb.cliff_thr);
			g = (sb.margin > 200) ? 200 : int'(sb.margin);
			v = t - (g + 2) + int'($urandom_range(0, 2 * g + 4));
			if (v < 0) v = 0;
			if (v > 4095) v = 4095;
			return v[drsc_pkg::SAMPLE_W-1:0];
		end
		return drsc_pkg::SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	function automatic logic [drsc_pkg::SAMPLE_W-1:0] pick_reg(bit is_margin);
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) return '0;
		if (r < 30) return '1;
		if (is_margin) return drsc_pkg::SAMPLE_W'($urandom_range(0, 300));
		return drsc_pkg::SAMPLE_W'($urandom_range(0, 4095));
	endfunction

	// Offer one item and wait for it to be taken
	task automatic send_item(logic cmd, logic [drsc_pkg::SAMPLE_W-1:0] l,
		logic [drsc_pkg::SAMPLE_W-1:0] r, bit no_gap);
		int gap;
		gap = no_gap ? 0 : gap_len(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {r, l};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cmd, l, r);
		n_items++;
		if (cmd == CMD_PRIME) n_prime++;
	endtask

	// Let everything in flight come out before touching registers
	task automatic wait_idle();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (sb.pending_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (5) @(posedge clk);
	endtask

	task automatic write_cfg(logic [drsc_pkg::SAMPLE_W-1:0] line_v,
		logic [drsc_pkg::SAMPLE_W-1:0] cliff_v, logic [drsc_pkg::SAMPLE_W-1:0] margin_v);
		cfg_we    <= 1'b1;
		cfg_index <= drsc_pkg::REG_LINE;
		cfg_data  <= line_v;
		@(posedge clk);
		sb.set_reg(drsc_pkg::REG_LINE, line_v);
		cfg_index <= drsc_pkg::REG_CLIFF;
		cfg_data  <= cliff_v;
		@(posedge clk);
		sb.set_reg(drsc_pkg::REG_CLIFF, cliff_v);
		cfg_index <= drsc_pkg::REG_MARGIN;
		cfg_data  <= margin_v;
		@(posedge clk);
		sb.set_reg(drsc_pkg::REG_MARGIN, margin_v);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	task automatic run_random(int count);
		logic cmd;
		repeat (count) begin
			cmd = ($urandom_range(0, 99) < 15) ? CMD_PRIME : CMD_UPDATE;
			send_item(cmd, pick_sample(), pick_sample(), 1'b0);
		end
	endtask

	// Result side: random stalls, long hold-offs on request
	initial begin
		int stall;
		stall = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) sb.check_result(m_tdata);
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				stall = gap_len(rx_calm);
				if (stall > 0) begin
					stall--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Main sequence
	initial begin
		sb         = new();
		tx_calm    = 0;
		rx_calm    = 0;
		hold_req   = 0;
		n_items    = 0;
		n_prime    = 0;
		n_settings = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= drsc_pkg::REG_LINE;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tuser   <= CMD_UPDATE;
		s_tdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, rails, threshold edges, prime keeps the slot
		send_item(CMD_UPDATE, 12'd0, 12'd0, 1'b0);
		send_item(CMD_UPDATE, 12'd4095, 12'd4095, 1'b0);
		send_item(CMD_PRIME, 12'd4095, 12'd0, 1'b0);
		send_item(CMD_PRIME, 12'd0, 12'd4095, 1'b0);
		send_item(CMD_PRIME, 12'd799, 12'd800, 1'b0);
		send_item(CMD_PRIME, 12'd750, 12'd751, 1'b0);
		send_item(CMD_PRIME, 12'd849, 12'd850, 1'b0);
		send_item(CMD_PRIME, 12'd2000, 12'd2001, 1'b0);
		send_item(CMD_PRIME, 12'd1950, 12'd1951, 1'b0);
		send_item(CMD_PRIME, 12'd2049, 12'd2050, 1'b0);
		send_item(CMD_PRIME, 12'haaa, 12'h555, 1'b0);
		repeat (5) send_item(CMD_UPDATE, 12'd4095, 12'd0, 1'b0);
		send_item(CMD_PRIME, 12'd1000, 12'd3000, 1'b0);
		repeat (7) send_item(CMD_UPDATE, 12'h555, 12'haaa, 1'b0);

		// Defaults, with a long receiver hold-off while the sender keeps pushing
		run_random(150);
		hold_req = 150;
		repeat (40) send_item(CMD_UPDATE, pick_sample(), pick_sample(), 1'b1);
		run_random(100);

		// Everything floor, no band
		wait_idle();
		write_cfg(12'd0, 12'd4095, 12'd0);
		run_random(280);

		// Fully overlapping thresholds, band wider than the range
		wait_idle();
		write_cfg(12'd4095, 12'd0, 12'd4095);
		run_random(280);

		// Overlap in the middle of the range
		wait_idle();
		write_cfg(12'd2000, 12'd1000, 12'd100);
		run_random(280);

		// Bands reaching past both rails
		wait_idle();
		write_cfg(12'd100, 12'd3900, 12'd300);
		run_random(280);

		// Random settings
		repeat (2) begin
			wait_idle();
			write_cfg(pick_reg(1'b0), pick_reg(1'b0), pick_reg(1'b1));
			run_random(280);
		end

		wait_idle();
		if (sb.pending_results.size() != 0) begin
			sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
		end
		$display("tb: %0d items sent (%0d prime), %0d results compared", n_items, n_prime,
			sb.checked);
		$display("tb: %0d register settings incl. rails, overlap and zero band", n_settings);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
